>>> rtl/sep_pkg.sv
// shared constants, types and the entropy score table for the pixel energy block
// no dependencies
`default_nettype none

package sep_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_DEPTH = 8 * MAX_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIX_W       = 8;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int CNT_W       = COL_W + ROW_W + 1;
   localparam int LIN_W       = ROW_W + WIDTH_W;
   localparam int NUM_BINS    = 9;
   localparam int BIN_W       = 4;
   localparam int BCNT_W      = 7;
   localparam int SCORE_W     = 6;
   localparam int ENT_W       = 9;
   localparam int ENERGY_W    = 12;
   localparam int TDATA_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int WIN_IDX_W   = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic PASS_RANGE = 1'b0;
   localparam logic PASS_BIN   = 1'b1;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd1024;

   localparam logic [SCORE_W-1:0] ENT_ROM [65] = '{
      6'd0,  6'd6,  6'd10, 6'd14, 6'd17, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28,
      6'd30, 6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd39,
      6'd40, 6'd41, 6'd41, 6'd41, 6'd42, 6'd42, 6'd42, 6'd42, 6'd43, 6'd43,
      6'd43, 6'd43, 6'd43, 6'd42, 6'd42, 6'd42, 6'd42, 6'd41, 6'd41, 6'd41,
      6'd40, 6'd40, 6'd39, 6'd39, 6'd38, 6'd38, 6'd37, 6'd37, 6'd36, 6'd35,
      6'd34, 6'd34, 6'd33, 6'd32, 6'd31, 6'd30, 6'd29, 6'd28, 6'd28, 6'd27,
      6'd26, 6'd25, 6'd23, 6'd22, 6'd21
   };

   typedef struct packed {
      logic start_pass;
      logic pass_sel;
      logic start_sum;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic emit_due;
      logic pass_done;
      logic sum_done;
      logic rsp_free;
   } stat_type;

   function automatic logic [SCORE_W-1:0] ent_score(input logic [BCNT_W-1:0] n);
      logic [SCORE_W-1:0] s;
      s = 6'd0;
      if (n <= 7'd64) begin
         s = ENT_ROM[n];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sobel_entropy_pixel_energy.sv
// seam energy per pixel: sobel l1 gradient plus 8x8 local entropy score
// an item with no result passes through the decide state and then frees the input again
// an item that produces an energy runs two 64-read passes
// over the row store ram (one read per cycle) plus a 9-step entropy sum
// synchronous active-high reset clears counters and control; row store is not cleared
`default_nettype none

module sobel_entropy_pixel_energy import sep_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIX_W-1:0]      req_tdata,   // pixel
   input  wire logic                  req_tuser,   // operation
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [TDATA_W-1:0]         rsp_tdata,   // energy, zero padding
   output logic                       rsp_tlast    // frame_end
);

   cmd_type             cmd;
   stat_type            stat;
   logic                idle;
   logic                req_accept;
   logic [ENERGY_W-1:0] energy;

   assign req_tready = idle;
   assign req_accept = req_tvalid && req_tready;

   sep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .stat       (stat),
      .cmd        (cmd),
      .idle       (idle)
   );

   sep_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_op     (req_tuser),
      .req_pixel  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_energy (energy),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(TDATA_W-ENERGY_W){1'b0}}, energy};

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded while the output register was still full");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input ready straight after a transfer");

   a_pass_done_busy: assert property (@(posedge clock) disable iff (reset)
      stat.pass_done |-> !req_tready)
      else $error("window pass finished while the controller was idle");

   a_sum_done_busy: assert property (@(posedge clock) disable iff (reset)
      stat.sum_done |-> !req_tready)
      else $error("entropy sum finished while the controller was idle");

endmodule

`default_nettype wire

>>> rtl/sep_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module sep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/sep_ctrl.sv
// sequencing state machine: window passes, entropy sum and result hand-off
// depends on sep_pkg
`default_nettype none

module sep_ctrl import sep_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_accept,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          idle
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_PASS0  = 3'd2;
   localparam logic [2:0] ST_PASS1  = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.emit_due) begin
               cmd.start_pass = 1'b1;
               cmd.pass_sel   = PASS_RANGE;
               state_in       = ST_PASS0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PASS0: begin
            if (stat.pass_done) begin
               cmd.start_pass = 1'b1;
               cmd.pass_sel   = PASS_BIN;
               state_in       = ST_PASS1;
            end
         end
         ST_PASS1: begin
            if (stat.pass_done) begin
               cmd.start_sum = 1'b1;
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            if (stat.sum_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/sep_datapath.sv
// counters, window address pipeline, range and binning passes, entropy sum, sobel and result register
// depends on sep_pkg and sep_ram
`default_nettype none

module sep_datapath import sep_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_accept,
   input  wire logic                  req_op,
   input  wire logic [PIX_W-1:0]      req_pixel,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [ENERGY_W-1:0]        rsp_energy,
   output logic                       rsp_last
);

   // configuration
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [COL_W-1:0]    w_m1;
   logic [ROW_W-1:0]    h_m1;
   logic [CNT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    lead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign w_m1 = COL_W'(w_eff - WIDTH_W'(1));
   assign h_m1 = ROW_W'(h_eff - HEIGHT_W'(1));

   always_ff @(posedge clock) begin
      total_ff <= CNT_W'(w_eff) * CNT_W'(h_eff);
      lead_ff  <= (CNT_W'(w_eff) << 1) + CNT_W'(w_eff) + CNT_W'(4);
   end

   // frame counters
   logic [CNT_W-1:0] pix_in_ff;
   logic [CNT_W-1:0] out_cnt_ff;
   logic [COL_W-1:0] out_x_ff;
   logic [ROW_W-1:0] out_y_ff;
   logic             wr_en;
   logic             frame_last;
   logic [CNT_W:0]   ready_sum;
   logic [CNT_W:0]   ready_lim;

   assign wr_en      = req_accept && (req_op == OP_PIXEL) && (pix_in_ff < total_ff);
   assign frame_last = ((out_cnt_ff + CNT_W'(1)) == total_ff);
   assign ready_sum  = {1'b0, out_cnt_ff} + {1'b0, lead_ff};
   assign ready_lim  = (ready_sum > {1'b0, total_ff}) ? {1'b0, total_ff} : ready_sum;

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         pix_in_ff  <= '0;
         out_cnt_ff <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
      end else if (cmd.emit && frame_last) begin
         pix_in_ff  <= '0;
         out_cnt_ff <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
      end else begin
         if (wr_en) begin
            pix_in_ff <= pix_in_ff + CNT_W'(1);
         end
         if (cmd.emit) begin
            out_cnt_ff <= out_cnt_ff + CNT_W'(1);
            if (out_x_ff == w_m1) begin
               out_x_ff <= '0;
               out_y_ff <= out_y_ff + ROW_W'(1);
            end else begin
               out_x_ff <= out_x_ff + COL_W'(1);
            end
         end
      end
   end

   // window address pipeline
   logic                 iss_act_ff;
   logic [WIN_IDX_W-1:0] iss_idx_ff;
   logic                 pass_sel_ff;
   logic                 s1_v_ff, s2_v_ff, s3_v_ff;
   logic [WIN_IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [ROW_W-1:0]     rr_ff;
   logic [COL_W-1:0]     cc_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic signed [ROW_W+1:0] row_s;
   logic signed [COL_W+1:0] col_s;
   logic [ROW_W-1:0]     rr_in;
   logic [COL_W-1:0]     cc_in;
   logic [LIN_W-1:0]     lin;
   logic [PIX_W-1:0]     rd_data;

   assign row_s = signed'({2'b00, out_y_ff}) + signed'({{(ROW_W-1){1'b0}}, iss_idx_ff[5:3]})
                  - signed'((ROW_W+2)'(4));
   assign col_s = signed'({2'b00, out_x_ff}) + signed'({{(COL_W-1){1'b0}}, iss_idx_ff[2:0]})
                  - signed'((COL_W+2)'(4));

   always_comb begin
      if (row_s < 0) begin
         rr_in = '0;
      end else if (row_s > signed'({2'b00, h_m1})) begin
         rr_in = h_m1;
      end else begin
         rr_in = row_s[ROW_W-1:0];
      end
      if (col_s < 0) begin
         cc_in = '0;
      end else if (col_s > signed'({2'b00, w_m1})) begin
         cc_in = w_m1;
      end else begin
         cc_in = col_s[COL_W-1:0];
      end
   end

   assign lin = LIN_W'(rr_ff) * LIN_W'(w_eff) + LIN_W'(cc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_act_ff <= 1'b0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
      end else begin
         if (cmd.start_pass) begin
            iss_act_ff <= 1'b1;
         end else if (iss_act_ff && (iss_idx_ff == '1)) begin
            iss_act_ff <= 1'b0;
         end
         s1_v_ff <= iss_act_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pass) begin
         iss_idx_ff  <= '0;
         pass_sel_ff <= cmd.pass_sel;
      end else if (iss_act_ff) begin
         iss_idx_ff <= iss_idx_ff + WIN_IDX_W'(1);
      end
      s1_idx_ff <= iss_idx_ff;
      rr_ff     <= rr_in;
      cc_ff     <= cc_in;
      s2_idx_ff <= s1_idx_ff;
      addr_ff   <= lin[ADDR_W-1:0];
      s3_idx_ff <= s2_idx_ff;
   end

   sep_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pix_in_ff[ADDR_W-1:0]),
      .wr_data (req_pixel),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // range pass: min, max and sobel taps
   logic [PIX_W-1:0] lo_ff, hi_ff;
   logic [PIX_W-1:0] tap_ff [NUM_BINS];
   logic             range_v;
   logic             bin_v;

   assign range_v = s3_v_ff && (pass_sel_ff == PASS_RANGE);
   assign bin_v   = s3_v_ff && (pass_sel_ff == PASS_BIN);

   always_ff @(posedge clock) begin
      if (cmd.start_pass && (cmd.pass_sel == PASS_RANGE)) begin
         lo_ff <= '1;
         hi_ff <= '0;
      end else if (range_v) begin
         if (rd_data < lo_ff) begin
            lo_ff <= rd_data;
         end
         if (rd_data > hi_ff) begin
            hi_ff <= rd_data;
         end
      end
      for (int k = 0; k < 9; k++) begin
         if (range_v && (s3_idx_ff[5:3] == 3'(3 + k / 3))
                     && (s3_idx_ff[2:0] == 3'(3 + k % 3))) begin
            tap_ff[k] <= rd_data;
         end
      end
   end

   // binning pass
   logic [8:0]         span;
   logic [11:0]        thr_ff [8];
   logic [PIX_W-1:0]   dv;
   logic [11:0]        d9;
   logic [BIN_W-1:0]   bin_in;
   logic [BIN_W-1:0]   bin_ff;
   logic               bin_v_ff;
   logic [BCNT_W-1:0]  count_ff [NUM_BINS];
   logic               pass_done_ff;

   assign span = {1'b0, hi_ff} - {1'b0, lo_ff} + 9'd1;
   assign dv   = rd_data - lo_ff;
   assign d9   = {1'b0, dv, 3'b000} + {4'b0000, dv};

   always_comb begin
      bin_in = '0;
      for (int k = 0; k < 8; k++) begin
         if (thr_ff[k] <= d9) begin
            bin_in = bin_in + BIN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 8; k++) begin
         thr_ff[k] <= 12'(span) * 12'(k + 1);
      end
      bin_ff <= bin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_v_ff     <= 1'b0;
         pass_done_ff <= 1'b0;
      end else begin
         bin_v_ff     <= bin_v;
         pass_done_ff <= s3_v_ff && (s3_idx_ff == '1);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_BINS; k++) begin
         if (cmd.start_pass && (cmd.pass_sel == PASS_RANGE)) begin
            count_ff[k] <= '0;
         end else if (bin_v_ff && (bin_ff == BIN_W'(k))) begin
            count_ff[k] <= count_ff[k] + BCNT_W'(1);
         end
      end
   end

   // entropy sum over the bins
   logic             sum_act_ff;
   logic             sum_done_ff;
   logic [BIN_W-1:0] sum_idx_ff;
   logic [ENT_W-1:0] ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_act_ff  <= 1'b0;
         sum_done_ff <= 1'b0;
      end else begin
         sum_done_ff <= sum_act_ff && (sum_idx_ff == BIN_W'(NUM_BINS - 1));
         if (cmd.start_sum) begin
            sum_act_ff <= 1'b1;
         end else if (sum_act_ff && (sum_idx_ff == BIN_W'(NUM_BINS - 1))) begin
            sum_act_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_sum) begin
         sum_idx_ff <= '0;
         ent_ff     <= '0;
      end else if (sum_act_ff) begin
         sum_idx_ff <= sum_idx_ff + BIN_W'(1);
         ent_ff     <= ent_ff + ENT_W'(ent_score(count_ff[sum_idx_ff]));
      end
   end

   // sobel l1 magnitude
   logic [9:0]        sx_pos, sx_neg, sy_pos, sy_neg;
   logic signed [10:0] gx, gy;
   logic [9:0]        ax, ay;
   logic [10:0]       grad_ff;

   assign sx_pos = 10'(tap_ff[2]) + {1'b0, tap_ff[5], 1'b0} + 10'(tap_ff[8]);
   assign sx_neg = 10'(tap_ff[0]) + {1'b0, tap_ff[3], 1'b0} + 10'(tap_ff[6]);
   assign sy_pos = 10'(tap_ff[6]) + {1'b0, tap_ff[7], 1'b0} + 10'(tap_ff[8]);
   assign sy_neg = 10'(tap_ff[0]) + {1'b0, tap_ff[1], 1'b0} + 10'(tap_ff[2]);
   assign gx     = signed'({1'b0, sx_pos}) - signed'({1'b0, sx_neg});
   assign gy     = signed'({1'b0, sy_pos}) - signed'({1'b0, sy_neg});
   assign ax     = (gx < 0) ? 10'(-gx) : gx[9:0];
   assign ay     = (gy < 0) ? 10'(-gy) : gy[9:0];

   always_ff @(posedge clock) begin
      grad_ff <= {1'b0, ax} + {1'b0, ay};
   end

   // result register
   logic                rsp_valid_ff;
   logic [ENERGY_W-1:0] rsp_energy_ff;
   logic                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_energy_ff <= ENERGY_W'(12'(grad_ff) + 12'(ent_ff));
         rsp_last_ff   <= frame_last;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_energy     = rsp_energy_ff;
   assign rsp_last       = rsp_last_ff;

   assign stat.emit_due  = (out_cnt_ff < total_ff) && ({1'b0, pix_in_ff} >= ready_lim);
   assign stat.pass_done = pass_done_ff;
   assign stat.sum_done  = sum_done_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

>>> verif/tb_sobel_entropy_pixel_energy.sv
// testbench for the seam energy block: directed table, then random frames of small sizes
// predicts energies with its own sobel and entropy model; depends on sep_pkg and the rtl
`timescale 1ns / 1ps

module tb_sobel_entropy_pixel_energy;
   import sep_pkg::*;

   localparam int SETTLE   = 200;
   localparam int WDOG_MAX = 5000;
   localparam int N_ITEMS  = 1250;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic                frame_end;
   } energy_type;

   typedef struct {
      int   ph;
      logic op;
      logic [PIX_W-1:0] pix;
      bit   known;
      bit   has;
      logic [ENERGY_W-1:0] en;
      logic fe;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic req_tuser = OP_PIXEL;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   sobel_entropy_pixel_energy u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [WIDTH_W-1:0]  cfg_width  = RESET_WIDTH;
   logic [HEIGHT_W-1:0] cfg_height = RESET_HEIGHT;
   logic [PIX_W-1:0]    line_mem [STORE_DEPTH];
   int unsigned px_count = 0;
   int unsigned en_count = 0;

   energy_type pending_energy [$];
   int  n_errors = 0;
   int  n_items = 0;
   int  n_energies = 0;
   int  n_frames = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;
   int  stall_left = 0;

   function automatic int eff_w();
      if (cfg_width == 0) return 1;
      return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
   endfunction

   function automatic int eff_h();
      if (cfg_height == 0) return 1;
      return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
   endfunction

   function automatic int grab(int r, int c, int w, int h);
      int rr, cc;
      rr = (r < 0) ? 0 : ((r > h - 1) ? h - 1 : r);
      cc = (c < 0) ? 0 : ((c > w - 1) ? w - 1 : c);
      return int'(line_mem[(rr * w + cc) % STORE_DEPTH]);
   endfunction

   function automatic logic [ENERGY_W-1:0] sobel_entropy(int x, int y, int w, int h);
      int a [3][3];
      int win [64];
      int counts [NUM_BINS];
      int gx, gy, lo, hi, b, ent;
      lo = 255;
      hi = 0;
      ent = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            a[i][j] = grab(y + i - 1, x + j - 1, w, h);
      gx = a[0][2] - a[0][0] + 2 * (a[1][2] - a[1][0]) + a[2][2] - a[2][0];
      gy = a[2][0] - a[0][0] + 2 * (a[2][1] - a[0][1]) + a[2][2] - a[0][2];
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      for (int i = 0; i < 64; i++) begin
         win[i] = grab(y + i / 8 - 4, x + i % 8 - 4, w, h);
         if (win[i] < lo) lo = win[i];
         if (win[i] > hi) hi = win[i];
      end
      for (int k = 0; k < NUM_BINS; k++) counts[k] = 0;
      for (int i = 0; i < 64; i++) begin
         b = (win[i] - lo) * NUM_BINS / (hi - lo + 1);
         counts[b > NUM_BINS - 1 ? NUM_BINS - 1 : b]++;
      end
      for (int k = 0; k < NUM_BINS; k++) ent += int'(ENT_ROM[counts[k]]);
      return ENERGY_W'(gx + gy + ent);
   endfunction

   // returns 1 when the item yields an energy
   function automatic bit next_energy(logic op, logic [PIX_W-1:0] pix, output energy_type res);
      int unsigned w, h, total, ready;
      w = eff_w();
      h = eff_h();
      total = w * h;
      res = '0;
      if (op == OP_PIXEL && px_count < total) begin
         line_mem[px_count % STORE_DEPTH] = pix;
         px_count++;
      end
      if (en_count >= total) return 1'b0;
      ready = en_count + 3 * w + 4;
      if (ready > total) ready = total;
      if (px_count < ready) return 1'b0;
      res.energy = sobel_entropy(en_count % w, en_count / w, w, h);
      en_count++;
      res.frame_end = (en_count == total);
      if (res.frame_end) begin
         px_count = 0;
         en_count = 0;
      end
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic op, logic [PIX_W-1:0] pix, bit known = 0, bit has = 0,
                       logic [ENERGY_W-1:0] en = '0, logic fe = 1'b0);
      energy_type res;
      bit got;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      got = next_energy(op, pix, res);
      if (known) begin
         got = has;
         res.energy = en;
         res.frame_end = fe;
      end
      if (got) pending_energy.push_back(res);
      n_items++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH) cfg_width = WIDTH_W'(val);
      else cfg_height = HEIGHT_W'(val);
      px_count = 0;
      en_count = 0;
   endtask

   task automatic set_frame(int unsigned w, int unsigned h);
      wait_idle();
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   // finish the frame in progress with drain transfers
   task automatic flush_frame();
      while (px_count != 0 || en_count != 0) send(OP_DRAIN, PIX_W'($urandom));
      n_frames++;
   endtask

   // one frame of pixels with random content and stray drains
   task automatic random_frame(int unsigned npix, int mode);
      logic [PIX_W-1:0] base;
      logic [PIX_W-1:0] p;
      base = PIX_W'($urandom);
      for (int unsigned i = 0; i < npix; i++) begin
         if ($urandom_range(0, 9) == 0) send(OP_DRAIN, PIX_W'($urandom));
         case (mode)
            0: p = base;
            1: p = base + PIX_W'($urandom_range(0, 5));
            2: p = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            default: p = PIX_W'($urandom);
         endcase
         send(OP_PIXEL, p);
      end
      // surplus pixels are dropped
      if (px_count != 0 && $urandom_range(0, 3) == 0) send(OP_PIXEL, PIX_W'($urandom));
   endtask

   row_type dir_rows [23] = '{
      '{0, OP_PIXEL, 8'h00, 1, 1, 12'd21, 1'b1},
      '{0, OP_PIXEL, 8'hff, 1, 1, 12'd21, 1'b1},
      '{0, OP_DRAIN, 8'h5a, 1, 0, 12'd0,  1'b0},
      '{0, OP_PIXEL, 8'h80, 1, 1, 12'd21, 1'b1},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'hff, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'hff, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'hff, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'hff, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'h80, 0, 0, 12'd0, 1'b0},
      '{1, OP_PIXEL, 8'h11, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'hff, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0},
      '{1, OP_DRAIN, 8'h00, 0, 0, 12'd0, 1'b0}
   };

   // result side: random back-pressure with some long stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
         stall_left <= $urandom_range(20, 60);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70);
      end
   end

   // result checker
   always @(posedge clock) begin
      energy_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_energies++;
         if (pending_energy.size() == 0) begin
            $error("energy transfer with nothing pending: energy %0d", rsp_tdata[ENERGY_W-1:0]);
            n_errors++;
         end else begin
            want = pending_energy.pop_front();
            if (rsp_tdata[ENERGY_W-1:0] !== want.energy) begin
               $error("energy: expected %0d, got %0d", want.energy, rsp_tdata[ENERGY_W-1:0]);
               n_errors++;
            end
            if (rsp_tdata[TDATA_W-1:ENERGY_W] !== '0) begin
               $error("tdata padding: expected 0, got %0h", rsp_tdata[TDATA_W-1:ENERGY_W]);
               n_errors++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_tlast);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("** sobel_entropy_pixel_energy: FAILED **");
         $finish;
      end
   end

   initial begin
      int w, h, mode, cur_ph;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      cur_ph = -1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].ph != cur_ph) begin
            cur_ph = dir_rows[i].ph;
            if (cur_ph == 0) set_frame(1, 1);
            else set_frame(3, 3);
         end
         send(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].known, dir_rows[i].has,
              dir_rows[i].en, dir_rows[i].fe);
      end
      flush_frame();

      // widest row, frame aborted by the next write
      set_frame(MAX_WIDTH, 1);
      random_frame(60, 3);
      // zero registers act as one
      set_frame(0, 0);
      random_frame(1, 3);
      flush_frame();
      // oversize registers, frame aborted by the next write
      set_frame(2047, 8191);
      random_frame(30, 3);
      set_frame(1, MAX_HEIGHT);
      random_frame(40, 1);
      set_frame(1, 1);

      // random frames
      while (n_items < N_ITEMS) begin
         w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         h = $urandom_range(1, 6);
         mode = $urandom_range(0, 5);
         no_gaps = ($urandom_range(0, 4) == 0);
         set_frame(w, h);
         random_frame(w * h, mode);
         flush_frame();
      end
      no_gaps = 1'b0;

      wait_idle();
      if (pending_energy.size() != 0) begin
         $error("energies still pending at the end: %0d", pending_energy.size());
         n_errors++;
      end
      $display("covered %0d input transfers, %0d energy transfers over %0d frames",
               n_items, n_energies, n_frames);
      $display("incl. width and height extremes, early drains and dropped surplus pixels");
      if (n_errors == 0) begin
         $display("** sobel_entropy_pixel_energy: PASSED **");
      end else begin
         $display("** sobel_entropy_pixel_energy: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/sep_pkg.sv
rtl/sep_ram.sv
rtl/sep_ctrl.sv
rtl/sep_datapath.sv
rtl/sobel_entropy_pixel_energy.sv
verif/tb_sobel_entropy_pixel_energy.sv
